[rtl/gvi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvi_pkg
// Shared sizes, register indexes and codes of the grid value iteration block.
// ----------------------------------------------------------------------------
package gvi_pkg;

  localparam int MAX_ROWS  = 8;
  localparam int MAX_COLS  = 8;
  localparam int FRAC_BITS = 16;

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ADDR_W = $clog2(2 * CELLS);
  localparam int DIM_W  = 8;

  localparam int VAL_W    = 32;
  localparam int DISC_W   = 16;
  localparam int REW_W    = 24;
  localparam int DIMCFG_W = 4;
  localparam int IDX_W    = 3;

  localparam int PROD_W = VAL_W + DISC_W + 1;
  localparam int SC_W   = PROD_W - FRAC_BITS;
  localparam int SUM_W  = SC_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_REW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_REW = 3'd6;

  localparam logic ACT_SWEEP = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic [1:0] MV_UP    = 2'd0;
  localparam logic [1:0] MV_DOWN  = 2'd1;
  localparam logic [1:0] MV_LEFT  = 2'd2;
  localparam logic [1:0] MV_RIGHT = 2'd3;

endpackage
`default_nettype wire

[rtl/gvi_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvi_if
// Request and result channels of the grid value iteration block.
// ----------------------------------------------------------------------------
interface gvi_in_if import gvi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;

  modport source (output valid, output action, output row, output col, input ready);
  modport sink   (input valid, input action, input row, input col, output ready);
endinterface

interface gvi_out_if import gvi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    was_read;

  modport source (output valid, output value, output was_read, input ready);
  modport sink   (input valid, input value, input was_read, output ready);
endinterface
`default_nettype wire

[rtl/gvi_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvi_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gvi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/grid_value_iteration_sweep.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_value_iteration_sweep
// Grid of utility values in two RAM banks, updated by value iteration sweeps
// and read back one cell at a time.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        word
//  in_ch    in   valid / ready    action, row, col
//  out_ch   out  valid / ready    value, was_read
//  cfg_*    in   we only          index, wdata
//
// A sweep issues one neighbor read per cycle from the value RAM, four per
// cell for all MAX_ROWS * MAX_COLS cells, then drains its pipeline stages
// s1 to s3. A read passes through ST_RDWAIT and then ST_FINISH.
// Per-entry valid bits clear at reset, so the RAM needs no clearing pass.
// A new word is taken while a finished result still waits on out_ch.
// ----------------------------------------------------------------------------
module grid_value_iteration_sweep import gvi_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  gvi_in_if.sink                     in_ch,
  gvi_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RDWAIT = 5'b00010,
    ST_SWEEP  = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);
  localparam logic [PROD_W-1:0] ROUND_C =
    {{(PROD_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

  function automatic logic [ADDR_W-1:0] entry_addr(input logic bank,
                                                   input logic [DIM_W-1:0] r,
                                                   input logic [DIM_W-1:0] c);
    logic [ADDR_W-1:0] lin;
    lin = ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
    entry_addr = bank ? lin + ADDR_W'(CELLS) : lin;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIMCFG_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] ve;
    ve = {{(DIM_W - DIMCFG_W){1'b0}}, v};
    if (ve == '0) begin
      clamp_dim = DIM_W'(1);
    end else if (ve > maxv) begin
      clamp_dim = maxv;
    end else begin
      clamp_dim = ve;
    end
  endfunction

  state_t state_r, state_nxt;

  logic [DIMCFG_W-1:0]     rows_r, cols_r;
  logic [IDX_W-1:0]        goal_row_r, goal_col_r;
  logic [DISC_W-1:0]       disc_r;
  logic signed [REW_W-1:0] goal_rew_r, step_rew_r;

  logic                    bank_r;
  logic [2*CELLS-1:0]      vld_r;
  logic                    vld_q_r;
  logic [ROW_W-1:0]        r_r;
  logic [COL_W-1:0]        c_r;
  logic [1:0]              m_r;
  logic                    rd_in_grid_r;

  logic                    s1_v_r, s2_v_r, s3_v_r;
  logic [1:0]              s1_m_r, s2_m_r, s3_m_r;
  logic                    s1_out_r, s2_out_r, s3_out_r;
  logic signed [REW_W-1:0] s1_rew_r, s2_rew_r, s3_rew_r;
  logic [ADDR_W-1:0]       s1_wa_r, s2_wa_r, s3_wa_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic signed [SC_W-1:0]  s3_sc_r;
  logic signed [VAL_W-1:0] best_r;

  logic signed [VAL_W-1:0] res_value_r, out_value_r;
  logic                    res_read_r, out_read_r, out_valid_r;

  logic [DIM_W-1:0]        nr, nc, rx, cx, tr, tc, in_rx, in_cx, goal_rx, goal_cx;
  logic                    cell_out, last_issue, in_acc, drained, out_load;
  logic signed [REW_W-1:0] s0_rew;
  logic [ADDR_W-1:0]       raddr, s0_wa;
  logic [VAL_W-1:0]        rdata;
  logic signed [VAL_W-1:0] s1_val, cand, best_nxt;
  logic signed [PROD_W-1:0] prod_nxt, rnd_full;
  logic signed [SUM_W-1:0] sum;
  logic                    ram_we;
  logic [VAL_W-1:0]        ram_wdata;

  assign nr      = clamp_dim(rows_r, DIM_W'(MAX_ROWS));
  assign nc      = clamp_dim(cols_r, DIM_W'(MAX_COLS));
  assign rx      = {{(DIM_W - ROW_W){1'b0}}, r_r};
  assign cx      = {{(DIM_W - COL_W){1'b0}}, c_r};
  assign in_rx   = {{(DIM_W - IDX_W){1'b0}}, in_ch.row};
  assign in_cx   = {{(DIM_W - IDX_W){1'b0}}, in_ch.col};
  assign goal_rx = {{(DIM_W - IDX_W){1'b0}}, goal_row_r};
  assign goal_cx = {{(DIM_W - IDX_W){1'b0}}, goal_col_r};

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && (state_r == ST_IDLE);

  always_comb begin
    tr = rx;
    tc = cx;
    case (m_r)
      MV_UP:    tr = (rx == '0) ? rx : rx - DIM_W'(1);
      MV_DOWN:  tr = (rx + DIM_W'(1) >= nr) ? rx : rx + DIM_W'(1);
      MV_LEFT:  tc = (cx == '0) ? cx : cx - DIM_W'(1);
      MV_RIGHT: tc = (cx + DIM_W'(1) >= nc) ? cx : cx + DIM_W'(1);
      default: begin
        tr = rx;
        tc = cx;
      end
    endcase
  end

  assign cell_out   = (rx >= nr) || (cx >= nc);
  assign s0_rew     = (tr == goal_rx && tc == goal_cx) ? goal_rew_r : step_rew_r;
  assign s0_wa      = entry_addr(~bank_r, rx, cx);
  assign raddr      = (state_r == ST_SWEEP) ? entry_addr(bank_r, tr, tc)
                                            : entry_addr(bank_r, in_rx, in_cx);
  assign last_issue = (r_r == ROW_LAST) && (c_r == COL_LAST) && (m_r == MV_RIGHT);
  assign drained    = !s1_v_r && !s2_v_r && !s3_v_r;
  assign out_load   = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);

  assign s1_val   = vld_q_r ? signed'(rdata) : '0;
  assign prod_nxt = signed'({1'b0, disc_r}) * s1_val;
  assign rnd_full = s2_prod_r + signed'(ROUND_C);
  assign sum      = {{(SUM_W - REW_W){s3_rew_r[REW_W-1]}}, s3_rew_r}
                  + {s3_sc_r[SC_W-1], s3_sc_r};

  always_comb begin
    if (!sum[SUM_W-1] && (|sum[SUM_W-2:VAL_W-1])) begin
      cand = {1'b0, {(VAL_W - 1){1'b1}}};
    end else if (sum[SUM_W-1] && !(&sum[SUM_W-2:VAL_W-1])) begin
      cand = {1'b1, {(VAL_W - 1){1'b0}}};
    end else begin
      cand = sum[VAL_W-1:0];
    end
    best_nxt = (s3_m_r == MV_UP || cand > best_r) ? cand : best_r;
  end

  assign ram_we    = s3_v_r && (s3_m_r == MV_RIGHT);
  assign ram_wdata = s3_out_r ? '0 : best_nxt;

  gvi_ram #(
    .WIDTH (VAL_W),
    .DEPTH (2 * CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s3_wa_r),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_ch.action == ACT_READ) ? ST_RDWAIT : ST_SWEEP;
        end
      end
      ST_RDWAIT: state_nxt = ST_FINISH;
      ST_SWEEP: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drained) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      rows_r      <= DIMCFG_W'(5);
      cols_r      <= DIMCFG_W'(5);
      goal_row_r  <= IDX_W'(4);
      goal_col_r  <= IDX_W'(4);
      disc_r      <= DISC_W'(49152);
      goal_rew_r  <= REW_W'(655360);
      step_rew_r  <= -REW_W'(65536);
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= (state_r == ST_SWEEP);
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      if (ram_we) begin
        vld_r[s3_wa_r] <= 1'b1;
      end
      if ((state_r == ST_DRAIN) && drained) begin
        bank_r <= ~bank_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS:     rows_r     <= cfg_wdata[DIMCFG_W-1:0];
          REG_COLS:     cols_r     <= cfg_wdata[DIMCFG_W-1:0];
          REG_GOAL_ROW: goal_row_r <= cfg_wdata[IDX_W-1:0];
          REG_GOAL_COL: goal_col_r <= cfg_wdata[IDX_W-1:0];
          REG_DISCOUNT: disc_r     <= cfg_wdata[DISC_W-1:0];
          REG_GOAL_REW: goal_rew_r <= signed'(cfg_wdata[REW_W-1:0]);
          REG_STEP_REW: step_rew_r <= signed'(cfg_wdata[REW_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_q_r <= vld_r[raddr];

    if (in_acc) begin
      r_r          <= '0;
      c_r          <= '0;
      m_r          <= MV_UP;
      rd_in_grid_r <= (in_rx < nr) && (in_cx < nc);
    end else if (state_r == ST_SWEEP) begin
      m_r <= m_r + 2'd1;
      if (m_r == MV_RIGHT) begin
        if (c_r == COL_LAST) begin
          c_r <= '0;
          r_r <= r_r + ROW_W'(1);
        end else begin
          c_r <= c_r + COL_W'(1);
        end
      end
    end

    s1_m_r   <= m_r;
    s1_out_r <= cell_out;
    s1_rew_r <= s0_rew;
    s1_wa_r  <= s0_wa;

    s2_m_r    <= s1_m_r;
    s2_out_r  <= s1_out_r;
    s2_rew_r  <= s1_rew_r;
    s2_wa_r   <= s1_wa_r;
    s2_prod_r <= prod_nxt;

    s3_m_r   <= s2_m_r;
    s3_out_r <= s2_out_r;
    s3_rew_r <= s2_rew_r;
    s3_wa_r  <= s2_wa_r;
    s3_sc_r  <= rnd_full[PROD_W-1:FRAC_BITS];

    if (s3_v_r) begin
      best_r <= best_nxt;
    end

    if (state_r == ST_RDWAIT) begin
      res_value_r <= rd_in_grid_r ? s1_val : '0;
      res_read_r  <= 1'b1;
    end else if ((state_r == ST_DRAIN) && drained) begin
      res_value_r <= '0;
      res_read_r  <= 1'b0;
    end

    if (out_load) begin
      out_value_r <= res_value_r;
      out_read_r  <= res_read_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.value    = out_value_r;
  assign out_ch.was_read = out_read_r;

endmodule
`default_nettype wire

[rtl/gvi_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvi_checker
// Port-level checks of the grid value iteration block, bound to the top level.
// ----------------------------------------------------------------------------
module gvi_checker import gvi_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    in_action,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [VAL_W-1:0] out_value,
  input wire logic                    out_was_read
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_was_read))
    else $error("result word changed while stalled");

  a_sweep_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_read |-> out_value == '0)
    else $error("sweep result carries a nonzero value");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one is still in work");

  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_SWEEP) |=> !$rose(out_valid))
    else $error("result appeared one cycle after a sweep request");

endmodule

bind grid_value_iteration_sweep gvi_checker u_gvi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_action    (in_ch.action),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_value    (out_ch.value),
  .out_was_read (out_ch.was_read)
);
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid value iteration sweep block. A scoreboard
// class keeps its own copy of both value banks and of the registers. It
// predicts every result from the accepted request words and compares each
// result word with the oldest prediction. The run has a directed part, then
// random phases with fresh register settings. One phase drives the grid into
// saturation. The phases vary sender gaps and receiver stalls, and one of
// them holds the receiver off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import gvi_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 600;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  class grid_scoreboard;
    typedef struct {
      logic signed [VAL_W-1:0] value;
      logic                    was_read;
    } cell_result_t;

    logic signed [VAL_W-1:0]  bank [2][CELLS];
    bit                       cur_bank;
    logic [DIMCFG_W-1:0]      rows_in_use;
    logic [DIMCFG_W-1:0]      cols_in_use;
    logic [IDX_W-1:0]         goal_row;
    logic [IDX_W-1:0]         goal_col;
    logic [DISC_W-1:0]        discount;
    logic signed [REW_W-1:0]  goal_reward;
    logic signed [REW_W-1:0]  step_reward;
    cell_result_t             pending_results[$];
    int                       errors;
    int                       sweeps;
    int                       reads;
    int                       saturations;

    function new();
      foreach (bank[b, i]) bank[b][i] = '0;
      cur_bank    = 1'b0;
      rows_in_use = 4'd5;
      cols_in_use = 4'd5;
      goal_row    = 3'd4;
      goal_col    = 3'd4;
      discount    = 16'd49152;
      goal_reward = 24'sd655360;
      step_reward = -24'sd65536;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ROWS:     rows_in_use = data[DIMCFG_W-1:0];
        REG_COLS:     cols_in_use = data[DIMCFG_W-1:0];
        REG_GOAL_ROW: goal_row    = data[IDX_W-1:0];
        REG_GOAL_COL: goal_col    = data[IDX_W-1:0];
        REG_DISCOUNT: discount    = data[DISC_W-1:0];
        REG_GOAL_REW: goal_reward = data[REW_W-1:0];
        REG_STEP_REW: step_reward = data[REW_W-1:0];
        default: ;
      endcase
    endfunction

    function int eff_dim(logic [DIMCFG_W-1:0] v, int maxv);
      if (v == 0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
    endfunction

    function logic signed [VAL_W-1:0] score_move(longint reward, logic signed [VAL_W-1:0] old);
      longint prod;
      longint total;
      prod  = longint'(discount) * longint'(old);
      total = reward + ((prod + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
      if (total > 64'sd2147483647) begin
        saturations++;
        return 32'sh7FFF_FFFF;
      end
      if (total < -64'sd2147483648) begin
        saturations++;
        return 32'sh8000_0000;
      end
      return VAL_W'(total);
    endfunction

    function void run_sweep();
      int nr;
      int nc;
      int tr;
      int tc;
      int dst;
      logic [1:0] mv;
      longint reward;
      logic signed [VAL_W-1:0] best;
      logic signed [VAL_W-1:0] cand;
      nr  = eff_dim(rows_in_use, MAX_ROWS);
      nc  = eff_dim(cols_in_use, MAX_COLS);
      dst = cur_bank ? 0 : 1;
      best = '0;
      for (int r = 0; r < MAX_ROWS; r++) begin
        for (int c = 0; c < MAX_COLS; c++) begin
          if (r >= nr || c >= nc) begin
            bank[dst][r * MAX_COLS + c] = '0;
          end else begin
            for (int m = 0; m < 4; m++) begin
              mv = 2'(m);
              tr = r;
              tc = c;
              case (mv)
                MV_UP:    tr = r - 1;
                MV_DOWN:  tr = r + 1;
                MV_LEFT:  tc = c - 1;
                MV_RIGHT: tc = c + 1;
                default: ;
              endcase
              if (tr < 0 || tc < 0 || tr >= nr || tc >= nc) begin
                tr = r;
                tc = c;
              end
              reward = (tr == int'(goal_row) && tc == int'(goal_col)) ?
                       longint'(goal_reward) : longint'(step_reward);
              cand = score_move(reward, bank[cur_bank][tr * MAX_COLS + tc]);
              if (m == 0 || cand > best) best = cand;
            end
            bank[dst][r * MAX_COLS + c] = best;
          end
        end
      end
      cur_bank = ~cur_bank;
    endfunction

    function void note_request(logic act, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
      cell_result_t res;
      if (act == ACT_SWEEP) begin
        run_sweep();
        res.value    = '0;
        res.was_read = 1'b0;
        sweeps++;
      end else begin
        res.value = '0;
        if (int'(r) < eff_dim(rows_in_use, MAX_ROWS) && int'(c) < eff_dim(cols_in_use, MAX_COLS))
          res.value = bank[cur_bank][int'(r) * MAX_COLS + int'(c)];
        res.was_read = 1'b1;
        reads++;
      end
      pending_results.insert(pending_results.size(), res);
    endfunction

    function void check_result(logic signed [VAL_W-1:0] value, logic was_read);
      cell_result_t exp_res;
      if (pending_results.size() == 0) begin
        $error("Result word with nothing expected: value %0d, was_read %0d", value, was_read);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (value !== exp_res.value) begin
        $error("Mismatch on value: expected %0d, actual %0d", exp_res.value, value);
        errors++;
      end
      if (was_read !== exp_res.was_read) begin
        $error("Mismatch on was_read: expected %0d, actual %0d", exp_res.was_read, was_read);
        errors++;
      end
    endfunction

    function bit idle();
      return pending_results.size() == 0;
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gvi_in_if  in_ch ();
  gvi_out_if out_ch ();

  grid_scoreboard sb = new();

  int src_idle_pct;
  int snk_stall_pct;
  bit hold_req;
  int stuck_cycles;
  int settings_used;

  grid_value_iteration_sweep DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.value, out_ch.was_read);
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.action, in_ch.row, in_ch.col);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles = stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      IDLE_SENDER:   begin src_idle_pct = 77; snk_stall_pct = 0;  end
      IDLE_RECEIVER: begin src_idle_pct = 0;  snk_stall_pct = 77; end
      default:       begin src_idle_pct = 14; snk_stall_pct = 14; end
    endcase
  endtask

  task automatic send_word(input logic act, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.row    <= r;
    in_ch.col    <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (!sb.idle()) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_config(input logic [DIMCFG_W-1:0] rows, input logic [DIMCFG_W-1:0] cols,
                              input logic [IDX_W-1:0] grow, input logic [IDX_W-1:0] gcol,
                              input logic [DISC_W-1:0] disc, input logic [REW_W-1:0] grew,
                              input logic [REW_W-1:0] srew);
    write_reg(REG_ROWS, (CFG_DATA_W'($urandom) & ~24'h00000F) | CFG_DATA_W'(rows));
    write_reg(REG_COLS, (CFG_DATA_W'($urandom) & ~24'h00000F) | CFG_DATA_W'(cols));
    write_reg(REG_GOAL_ROW, (CFG_DATA_W'($urandom) & ~24'h000007) | CFG_DATA_W'(grow));
    write_reg(REG_GOAL_COL, (CFG_DATA_W'($urandom) & ~24'h000007) | CFG_DATA_W'(gcol));
    write_reg(REG_DISCOUNT, (CFG_DATA_W'($urandom) & ~24'h00FFFF) | CFG_DATA_W'(disc));
    write_reg(REG_GOAL_REW, grew);
    write_reg(REG_STEP_REW, srew);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [DIMCFG_W-1:0] pick_dim();
    case ($urandom_range(5))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd8;
      3: return 4'd15;
      default: return DIMCFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [REW_W-1:0] pick_reward();
    case ($urandom_range(4))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return '0;
      3: return REW_W'($urandom);
      default: return REW_W'($urandom_range(0, 32'h0040_0000)) - 24'h200000;
    endcase
  endfunction

  task automatic random_config();
    logic [DISC_W-1:0] disc;
    case ($urandom_range(3))
      0: disc = '0;
      1: disc = '1;
      default: disc = DISC_W'($urandom);
    endcase
    apply_config(pick_dim(), pick_dim(), IDX_W'($urandom), IDX_W'($urandom), disc,
                 pick_reward(), pick_reward());
  endtask

  task automatic run_phase(input int n_items, input int sweep_pct);
    for (int i = 0; i < n_items; i++) begin
      send_word(($urandom_range(99) < sweep_pct) ? ACT_SWEEP : ACT_READ,
                IDX_W'($urandom), IDX_W'($urandom));
    end
    drain_results();
  endtask

  initial begin
    idle_mode_t modes [4];
    modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
    stuck_cycles  = 0;
    settings_used = 1;
    hold_req      = 1'b0;
    set_idle(IDLE_NONE);
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.action <= ACT_SWEEP;
    in_ch.row    <= '0;
    in_ch.col    <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Settings after reset: cleared grid, reads inside and outside the grid.
    send_word(ACT_READ, 3'd0, 3'd0);
    send_word(ACT_READ, 3'd7, 3'd7);
    send_word(ACT_SWEEP, 3'd7, 3'd0);
    send_word(ACT_READ, 3'd4, 3'd4);
    send_word(ACT_READ, 3'd3, 3'd4);
    send_word(ACT_READ, 3'd0, 3'd0);
    send_word(ACT_SWEEP, 3'd0, 3'd7);
    send_word(ACT_READ, 3'd4, 3'd3);
    send_word(ACT_READ, 3'd5, 3'd5);
    drain_results();

    // Zero rows count as one, oversize columns as eight, extreme rewards.
    apply_config(4'd0, 4'd15, 3'd0, 3'd7, 16'hFFFF, 24'h7FFFFF, 24'h800000);
    send_word(ACT_SWEEP, 3'd0, 3'd0);
    send_word(ACT_READ, 3'd0, 3'd7);
    send_word(ACT_READ, 3'd0, 3'd0);
    send_word(ACT_READ, 3'd1, 3'd0);
    send_word(ACT_SWEEP, 3'd7, 3'd7);
    send_word(ACT_READ, 3'd0, 3'd6);
    drain_results();

    // Grid enlarged without a sweep, then a sweep with zero discount.
    apply_config(4'd8, 4'd8, 3'd7, 3'd7, 16'h0000, 24'h000000, 24'h7FFFFF);
    send_word(ACT_READ, 3'd3, 3'd3);
    send_word(ACT_SWEEP, 3'd0, 3'd0);
    send_word(ACT_READ, 3'd7, 3'd7);
    send_word(ACT_READ, 3'd0, 3'd0);
    drain_results();

    // Goal outside the grid in use.
    apply_config(4'd2, 4'd3, 3'd5, 3'd5, 16'd49152, 24'h0A0000, 24'hFF0000);
    send_word(ACT_SWEEP, 3'd1, 3'd1);
    send_word(ACT_READ, 3'd1, 3'd2);
    send_word(ACT_READ, 3'd2, 3'd0);
    drain_results();

    // Full grid, near-unit discount and top rewards until values saturate.
    set_idle(IDLE_BOTH);
    apply_config(4'd8, 4'd8, IDX_W'($urandom), IDX_W'($urandom), 16'hFFFF,
                 24'h7FFFFF, 24'h7FFFFF);
    run_phase(320, 95);

    // Receiver held off while the sender keeps offering words.
    set_idle(IDLE_NONE);
    random_config();
    hold_req = 1'b1;
    run_phase(60, 10);

    for (int p = 0; p < 8; p++) begin
      set_idle(modes[p % 4]);
      random_config();
      run_phase(55, 30);
    end

    repeat (20) @(posedge clk);
    if (!sb.idle()) begin
      $error("%0d expected results never arrived", sb.pending_results.size());
      sb.errors++;
    end
    $display("Run covered %0d sweeps and %0d cell reads under %0d register settings.",
             sb.sweeps, sb.reads, settings_used);
    $display("Saturated moves: %0d; one receiver hold-off of %0d cycles.",
             sb.saturations, HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[grid_value_iteration_sweep.f]
rtl/gvi_pkg.sv
rtl/gvi_if.sv
rtl/gvi_ram.sv
rtl/grid_value_iteration_sweep.sv
rtl/gvi_checker.sv
dv/tb_top.sv
